// ===== hw/rtl/bitmap_rle_stream_decoder_defines.svh =====
// Assertion macros shared by the run-length bitmap decoder RTL.
// No dependencies; define NO_ASSERTIONS to compile every check away.
`ifndef BITMAP_RLE_STREAM_DECODER_DEFINES_SVH
`define BITMAP_RLE_STREAM_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define BRSD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BRSD_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define BRSD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/bmprle_pkg.sv =====
// Shared types and constants of the run-length bitmap decoder.
// No dependencies; used by bitmap_rle_stream_decoder.
`default_nettype none

package bmprle_pkg;

    localparam int MAX_DIMENSION_DEFAULT = 16384;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int DIM_CFG_W   = 15;
    localparam int POS_OUT_W   = 14;
    localparam int CAUSE_W     = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int OUT_TDATA_W = 56;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Result kinds and finish causes
    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [CAUSE_W-1:0] CAUSE_END_MARKER = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_LINES_DONE = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_STREAM_END = 2'd2;

    // Escape codes following a zero command byte
    localparam logic [BYTE_W-1:0] ESC_END_LINE   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_END_BITMAP = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA      = 8'd2;

    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [1:0]           fill;
        logic [BYTE_W-1:0]    odd_value;
        logic [BYTE_W-1:0]    even_value;
        logic [BYTE_W-1:0]    pixel_count;
        logic [POS_OUT_W-1:0] start_column;
        logic [POS_OUT_W-1:0] line_index;
        logic [CAUSE_W-1:0]   finish_cause;
    } result_data_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_rle_stream_decoder.sv =====
// Run-length bitmap stream decoder (8-bit and 4-bit modes), single module.
// Depends on bmprle_pkg and bitmap_rle_stream_decoder_defines.svh.
//
//   channel  direction  handshake          payload
//   s_       in         s_tvalid/s_tready  s_tdata = data_byte, s_tlast = stream_end
//   m_       out        m_tvalid/m_tready  m_tuser = result_kind, m_tdata = descriptor
//   cfg_     in         cfg_valid/ready    cfg_index, cfg_data
//
// One compressed byte per cycle, sustained while the result stream is not stalled.
// A byte is taken into the input register and decoded from there into the result
// register. The decode stage advances whenever the result register is empty or
// being drained, so an output stall only backs up one result and one byte. Reset
// is synchronous and leaves the block ready on the next cycle; there is no storage
// to clear.
`default_nettype none

`include "bitmap_rle_stream_decoder_defines.svh"

module bitmap_rle_stream_decoder #(
    parameter int MAX_DIMENSION = bmprle_pkg::MAX_DIMENSION_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [bmprle_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] data_byte
    input  wire logic                                  s_tlast,   // stream_end
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [1:0] finish_cause, [15:2] line_index, [29:16] start_column,
    // [37:30] pixel_count, [45:38] even_value, [53:46] odd_value, [55:54] zero
    output logic [bmprle_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                       m_tuser,   // [0] result_kind
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bmprle_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bmprle_pkg::DIM_CFG_W-1:0]      cfg_data
);
    import bmprle_pkg::*;

    // Internal position width: holds any clamped width/height
    localparam int DIM_W = $clog2(MAX_DIMENSION) + 1;
    // Width used to compare a raw register against the bound
    localparam int EXT_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    // Width of position + one byte (delta steps)
    localparam int SUM_W = ((DIM_W > BYTE_W) ? DIM_W : BYTE_W) + 1;
    // Width for comparing pixels left against a byte count
    localparam int CL_W  = (DIM_W > BYTE_W) ? DIM_W : BYTE_W;

    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIMENSION);

    typedef enum logic [2:0] {
        PH_CMD, PH_RUNVAL, PH_ESC, PH_DX, PH_DY, PH_LIT, PH_PAD, PH_DONE
    } phase_t;

    // Configuration
    logic                  nibble_reg;
    logic [DIM_CFG_W-1:0]  width_cfg_reg;
    logic [DIM_CFG_W-1:0]  height_cfg_reg;

    // Parser state
    phase_t                phase_reg,    phase_next;
    logic [DIM_W-1:0]      column_reg,   column_next;
    logic [DIM_W-1:0]      line_reg,     line_next;
    logic [BYTE_W-1:0]     run_len_reg,  run_len_next;
    logic [BYTE_W-1:0]     lit_left_reg, lit_left_next;
    logic                  pad_reg,      pad_next;

    // Input register
    logic                  in_valid_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_end_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_kind_reg,  out_kind_next;
    result_data_t          out_data_reg,  out_data_next;

    logic                  proc_fire;
    logic                  emit;
    logic [DIM_W-1:0]      eff_w;
    logic [DIM_W-1:0]      eff_h;
    logic [DIM_W-1:0]      pix_left;
    logic [BYTE_W-1:0]     clamped;
    logic [DIM_W-1:0]      line_inc;
    logic [SUM_W-1:0]      col_sum;
    logic [SUM_W-1:0]      line_sum;
    logic [BYTE_W:0]       clamped_inc;

    // Effective dimensions: zero acts as one, anything above the bound is the bound
    always_comb begin
        logic [EXT_W-1:0] w_ext;
        logic [EXT_W-1:0] h_ext;
        w_ext = EXT_W'(width_cfg_reg);
        h_ext = EXT_W'(height_cfg_reg);
        if (width_cfg_reg == '0) begin
            eff_w = DIM_W'(1);
        end else if (w_ext > MAX_EXT) begin
            eff_w = DIM_W'(MAX_DIMENSION);
        end else begin
            eff_w = DIM_W'(w_ext);
        end
        if (height_cfg_reg == '0) begin
            eff_h = DIM_W'(1);
        end else if (h_ext > MAX_EXT) begin
            eff_h = DIM_W'(MAX_DIMENSION);
        end else begin
            eff_h = DIM_W'(h_ext);
        end
    end

    // Count clamped to the pixels left in the row
    always_comb begin
        pix_left = (column_reg >= eff_w) ? '0 : (eff_w - column_reg);
        if (CL_W'(pix_left) < CL_W'(in_byte_reg)) begin
            clamped = BYTE_W'(pix_left);
        end else begin
            clamped = in_byte_reg;
        end
        clamped_inc = {1'b0, clamped} + (BYTE_W+1)'(1);
        line_inc    = line_reg + DIM_W'(1);
        col_sum     = SUM_W'(column_reg) + SUM_W'(in_byte_reg);
        line_sum    = SUM_W'(line_reg) + SUM_W'(in_byte_reg);
    end

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);

    // Decode of one byte
    always_comb begin
        logic [BYTE_W-1:0] ev;
        logic [BYTE_W-1:0] ov;
        logic [BYTE_W-1:0] cnt;
        logic              finish;
        logic [CAUSE_W-1:0] cause;

        phase_next    = phase_reg;
        column_next   = column_reg;
        line_next     = line_reg;
        run_len_next  = run_len_reg;
        lit_left_next = lit_left_reg;
        pad_next      = pad_reg;
        emit          = 1'b0;
        finish        = 1'b0;
        cause         = CAUSE_END_MARKER;
        cnt           = '0;

        // Pixel values for this byte in the current mode
        if (nibble_reg) begin
            ev = {4'b0000, in_byte_reg[7:4]};
            ov = in_byte_reg & NIBBLE_MASK;
        end else begin
            ev = in_byte_reg;
            ov = in_byte_reg;
        end

        if (phase_reg == PH_DONE) begin
            // ignore everything until reset
        end else if (in_end_reg) begin
            finish = 1'b1;
            cause  = CAUSE_STREAM_END;
        end else if (line_reg >= eff_h) begin
            finish = 1'b1;
            cause  = CAUSE_LINES_DONE;
        end else begin
            case (phase_reg)
                PH_CMD: begin
                    if (in_byte_reg == '0) begin
                        phase_next = PH_ESC;
                    end else begin
                        run_len_next = clamped;
                        phase_next   = PH_RUNVAL;
                    end
                end
                PH_RUNVAL: begin
                    phase_next   = PH_CMD;
                    run_len_next = '0;
                    if (run_len_reg != '0) begin
                        emit = 1'b1;
                        cnt  = run_len_reg;
                    end
                end
                PH_ESC: begin
                    if (in_byte_reg == ESC_END_LINE) begin
                        column_next = '0;
                        line_next   = line_inc;
                        phase_next  = PH_CMD;
                        if (line_inc >= eff_h) begin
                            finish = 1'b1;
                            cause  = CAUSE_LINES_DONE;
                        end
                    end else if (in_byte_reg == ESC_END_BITMAP) begin
                        finish = 1'b1;
                        cause  = CAUSE_END_MARKER;
                    end else if (in_byte_reg == ESC_DELTA) begin
                        phase_next = PH_DX;
                    end else begin
                        // absolute run; pad to a 16-bit word of literal bytes
                        lit_left_next = clamped;
                        pad_next      = nibble_reg ? clamped_inc[1] : clamped[0];
                        phase_next    = (clamped != '0) ? PH_LIT : PH_CMD;
                    end
                end
                PH_DX: begin
                    if (col_sum >= SUM_W'(eff_w)) begin
                        column_next = eff_w - DIM_W'(1);
                    end else begin
                        column_next = DIM_W'(col_sum);
                    end
                    phase_next = PH_DY;
                end
                PH_DY: begin
                    if (line_sum >= SUM_W'(eff_h)) begin
                        line_next = eff_h - DIM_W'(1);
                    end else begin
                        line_next = DIM_W'(line_sum);
                    end
                    phase_next = PH_CMD;
                end
                PH_LIT: begin
                    if (lit_left_reg == '0) begin
                        phase_next = PH_CMD;
                    end else begin
                        emit = 1'b1;
                        if (nibble_reg && (lit_left_reg >= BYTE_W'(2))) begin
                            cnt = BYTE_W'(2);
                        end else begin
                            cnt = BYTE_W'(1);
                        end
                        lit_left_next = lit_left_reg - cnt;
                        if (lit_left_reg != cnt) begin
                            phase_next = PH_LIT;
                        end else begin
                            phase_next = pad_reg ? PH_PAD : PH_CMD;
                        end
                    end
                end
                PH_PAD: begin
                    pad_next   = 1'b0;
                    phase_next = PH_CMD;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end

        out_data_next      = '0;
        out_kind_next      = KIND_RUN;
        if (finish) begin
            emit                       = 1'b1;
            phase_next                 = PH_DONE;
            out_kind_next              = KIND_FINISH;
            out_data_next.finish_cause = cause;
        end else if (emit) begin
            out_data_next.line_index   = POS_OUT_W'(line_reg);
            out_data_next.start_column = POS_OUT_W'(column_reg);
            out_data_next.pixel_count  = cnt;
            out_data_next.even_value   = ev;
            out_data_next.odd_value    = ov;
            column_next                = column_reg + DIM_W'(cnt);
        end
    end

    // All state, configuration and both registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_reg     <= 1'b0;
            width_cfg_reg  <= DIM_CFG_W'(1);
            height_cfg_reg <= DIM_CFG_W'(1);
            phase_reg      <= PH_CMD;
            column_reg     <= '0;
            line_reg       <= '0;
            run_len_reg    <= '0;
            lit_left_reg   <= '0;
            pad_reg        <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NIBBLE_MODE:  nibble_reg     <= cfg_data[0];
                    CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (proc_fire) begin
                phase_reg    <= phase_next;
                column_reg   <= column_next;
                line_reg     <= line_next;
                run_len_reg  <= run_len_next;
                lit_left_reg <= lit_left_next;
                pad_reg      <= pad_next;
            end

            if (proc_fire && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end

        // payload registers, no reset
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (proc_fire && emit) begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
        end
    end

    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_kind_reg;
    assign cfg_ready = 1'b1;

    // A finish result carries nothing but its cause
    `BRSD_ASSERT_NOW(a_finish_payload_zero, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_FINISH), m_tdata[OUT_TDATA_W-1:CAUSE_W] == '0,
        "finish result with non-zero payload")

    // A pixel run always writes at least one pixel
    `BRSD_ASSERT_NOW(a_run_count_nonzero, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_RUN), m_tdata[37:30] != '0,
        "pixel run with zero count")

    // Once a finish result is pending, the parser has stopped
    `BRSD_ASSERT_NOW(a_finish_means_done, aclk, aresetn,
        m_tvalid && (m_tuser == KIND_FINISH), phase_reg == PH_DONE,
        "finish result while parser still active")

    // The finished state is only left through reset
    `BRSD_ASSERT_NEXT(a_done_sticky, aclk, aresetn,
        phase_reg == PH_DONE, phase_reg == PH_DONE,
        "parser left the finished state")

endmodule

`default_nettype wire

// ===== dv/tb_bitmap_rle_stream_decoder.sv =====
// Self-checking bench for bitmap_rle_stream_decoder: byte stream in, run descriptors out.
// Needs bmprle_pkg and the decoder RTL; a built-in predictor checks every descriptor.
`default_nettype none

module tb_bitmap_rle_stream_decoder;
    import bmprle_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_BYTES    = 115;

    // parse phases of the decoder, as the predictor tracks them
    typedef enum logic [2:0] {
        ST_CMD, ST_RUN_VALUE, ST_ESCAPE, ST_DELTA_X, ST_DELTA_Y, ST_LITERAL, ST_PAD,
        ST_FINISHED
    } parse_phase_t;

    typedef struct packed {
        parse_phase_t           phase;
        logic [DIM_CFG_W-1:0]   column;
        logic [DIM_CFG_W-1:0]   line;
        logic [BYTE_W-1:0]      run_len;
        logic [BYTE_W-1:0]      lit_left;
        logic                   pad;
    } decode_state_t;

    typedef struct packed {
        logic                 nibble;
        logic [DIM_CFG_W-1:0] width;
        logic [DIM_CFG_W-1:0] height;
    } decode_regs_t;

    typedef struct packed {
        logic         kind;
        result_data_t data;
    } descriptor_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } stream_byte_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DIM_CFG_W-1:0] cfg_data = '0;

    bitmap_rle_stream_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stream_byte_t  pending_bytes[$];   // bytes waiting for the input driver
    descriptor_t   expected_descs[$];  // descriptors predicted, not yet seen
    decode_state_t decoder_state;      // predictor, advanced on accepted requests
    decode_state_t plan_state;         // same decoder, advanced as bytes are queued
    decode_regs_t  regs;
    int  errors = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  s_taken = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic int eff_dim(logic [DIM_CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIMENSION_DEFAULT)
            return MAX_DIMENSION_DEFAULT;
        return int'(v);
    endfunction

    // Decodes one stream byte; returns 1 with the descriptor it produces.
    function automatic bit decode_byte(inout decode_state_t st, input decode_regs_t r,
                                       input logic [BYTE_W-1:0] b, input logic last,
                                       output descriptor_t res);
        int w, h, left, cnt, n;
        bit fin;
        logic [CAUSE_W-1:0] cause;
        logic [BYTE_W-1:0] ev, ov;
        w     = eff_dim(r.width);
        h     = eff_dim(r.height);
        left  = (st.column >= w) ? 0 : w - st.column;
        cnt   = 0;
        fin   = 1'b0;
        cause = CAUSE_END_MARKER;
        ev    = r.nibble ? (b >> 4) : b;
        ov    = r.nibble ? (b & NIBBLE_MASK) : b;
        res   = '0;
        if (st.phase == ST_FINISHED)
            return 1'b0;
        if (last) begin
            fin   = 1'b1;
            cause = CAUSE_STREAM_END;
        end else if (st.line >= h) begin
            fin   = 1'b1;
            cause = CAUSE_LINES_DONE;
        end else begin
            case (st.phase)
                ST_CMD: begin
                    if (b == 0) begin
                        st.phase = ST_ESCAPE;
                    end else begin
                        st.run_len = (b > left) ? BYTE_W'(left) : b;
                        st.phase   = ST_RUN_VALUE;
                    end
                end
                ST_RUN_VALUE: begin
                    cnt        = st.run_len;
                    st.run_len = '0;
                    st.phase   = ST_CMD;
                end
                ST_ESCAPE: begin
                    if (b == ESC_END_LINE) begin
                        st.column = '0;
                        st.line   = st.line + 1'b1;
                        st.phase  = ST_CMD;
                        if (st.line >= h) begin
                            fin   = 1'b1;
                            cause = CAUSE_LINES_DONE;
                        end
                    end else if (b == ESC_END_BITMAP) begin
                        fin   = 1'b1;
                        cause = CAUSE_END_MARKER;
                    end else if (b == ESC_DELTA) begin
                        st.phase = ST_DELTA_X;
                    end else begin
                        n           = (b > left) ? left : b;
                        st.lit_left = BYTE_W'(n);
                        // odd number of stream bytes means one pad byte follows
                        st.pad      = 1'(r.nibble ? (((n + 1) >> 1) & 1) : (n & 1));
                        st.phase    = (n != 0) ? ST_LITERAL : ST_CMD;
                    end
                end
                ST_DELTA_X: begin
                    n = st.column + b;
                    if (n >= w)
                        n = w - 1;
                    st.column = DIM_CFG_W'(n);
                    st.phase  = ST_DELTA_Y;
                end
                ST_DELTA_Y: begin
                    n = st.line + b;
                    if (n >= h)
                        n = h - 1;
                    st.line  = DIM_CFG_W'(n);
                    st.phase = ST_CMD;
                end
                ST_LITERAL: begin
                    if (st.lit_left == 0) begin
                        st.phase = ST_CMD;
                    end else begin
                        cnt         = (r.nibble && st.lit_left >= 2) ? 2 : 1;
                        st.lit_left = st.lit_left - BYTE_W'(cnt);
                        st.phase    = (st.lit_left != 0) ? ST_LITERAL :
                                      (st.pad ? ST_PAD : ST_CMD);
                    end
                end
                ST_PAD: begin
                    st.pad   = 1'b0;
                    st.phase = ST_CMD;
                end
                default: st.phase = ST_FINISHED;
            endcase
        end
        if (fin) begin
            st.phase              = ST_FINISHED;
            res.kind              = KIND_FINISH;
            res.data.finish_cause = cause;
            return 1'b1;
        end
        if (cnt == 0)
            return 1'b0;
        res.kind              = KIND_RUN;
        res.data.line_index   = st.line[POS_OUT_W-1:0];
        res.data.start_column = st.column[POS_OUT_W-1:0];
        res.data.pixel_count  = BYTE_W'(cnt);
        res.data.even_value   = ev;
        res.data.odd_value    = ov;
        st.column             = st.column + DIM_CFG_W'(cnt);
        return 1'b1;
    endfunction

    // Next byte of a mostly well-formed stream, driven by the planned parse phase.
    // Never ends the decode: no end marker, no end of line on the last line.
    function automatic logic [BYTE_W-1:0] pick_byte(decode_state_t st);
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if ($urandom_range(0, 15) != 0) begin
            case (st.phase)
                ST_CMD: begin
                    if ($urandom_range(0, 3) == 0)
                        b = '0;
                    else if ($urandom_range(0, 2) == 0)
                        b = BYTE_W'($urandom_range(1, 255));
                    else
                        b = BYTE_W'($urandom_range(1, 8));
                end
                ST_ESCAPE: begin
                    case ($urandom_range(0, 3))
                        0: b = ESC_END_LINE;
                        1: b = ESC_DELTA;
                        default: b = ($urandom_range(0, 4) == 0) ?
                                     BYTE_W'($urandom_range(3, 255)) :
                                     BYTE_W'($urandom_range(3, 12));
                    endcase
                end
                ST_DELTA_X: b = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom) :
                                BYTE_W'($urandom_range(0, 6));
                ST_DELTA_Y: begin
                    if ($urandom_range(0, 39) == 0)
                        b = 8'hff;
                    else if ($urandom_range(0, 9) == 0)
                        b = BYTE_W'($urandom_range(1, 3));
                    else
                        b = '0;
                end
                default: ;
            endcase
        end
        if (st.phase == ST_ESCAPE && (b == ESC_END_BITMAP ||
                (b == ESC_END_LINE && st.line + 1 >= eff_dim(regs.height))))
            b = ESC_DELTA;
        return b;
    endfunction

    function automatic void send(logic [BYTE_W-1:0] b, logic last);
        descriptor_t unused;
        pending_bytes.push_back('{data: b, last: last});
        void'(decode_byte(plan_state, regs, b, last, unused));
    endfunction

    // keep feeding well-formed bytes until the planned parser waits for a command
    function automatic void settle();
        while (plan_state.phase != ST_CMD)
            send(pick_byte(plan_state), 1'b0);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Register writes only happen with the decoder idle.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DIM_CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_NIBBLE_MODE:  regs.nibble = val[0];
            CFG_IMAGE_WIDTH:  regs.width  = val;
            CFG_IMAGE_HEIGHT: regs.height = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued request is taken and every descriptor is back,
    // then wait on so that a taken byte that produces nothing leaves the decoder too.
    task automatic drain();
        while (pending_bytes.size() != 0 || s_tvalid || expected_descs.size() != 0)
            @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    // Input driver: presents the next queued byte once the previous request is taken.
    always @(negedge aclk) begin
        stream_byte_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                req = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= req.data;
                s_tlast  <= req.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with random back-pressure.
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: checks descriptors, predicts from accepted requests, feeds the watchdog.
    always @(posedge aclk) begin
        descriptor_t got, want, res;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = m_tuser;
            got.data = m_tdata;
            if (expected_descs.size() == 0) begin
                errors++;
                $display("%0t: descriptor mismatch, expected none, actual kind %0b tdata %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = expected_descs.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("finish_cause", want.data.finish_cause, got.data.finish_cause);
                check_field("line_index", want.data.line_index, got.data.line_index);
                check_field("start_column", want.data.start_column, got.data.start_column);
                check_field("pixel_count", want.data.pixel_count, got.data.pixel_count);
                check_field("even_value", want.data.even_value, got.data.even_value);
                check_field("odd_value", want.data.odd_value, got.data.odd_value);
                check_field("tdata fill", want.data.fill, got.data.fill);
            end
        end
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            if (decode_byte(decoder_state, regs, s_tdata, s_tlast, res))
                expected_descs.push_back(res);
        end
        if (s_taken || (aresetn && ((m_tvalid && m_tready) || (cfg_valid && cfg_ready))))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int ending;
        decoder_state = '{phase: ST_CMD, default: '0};
        plan_state    = '{phase: ST_CMD, default: '0};
        regs          = '{nibble: 1'b0, width: 15'd1, height: 15'd1};
        send_idle_pct = 9;
        recv_idle_pct = 77;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Degenerate image: width and height of 0 both act as 1.
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        write_reg(CFG_NIBBLE_MODE, 15'd0);
        send(8'd255, 1'b0);            // longest run, clamps to one pixel
        send(8'hff, 1'b0);
        send(8'd1, 1'b0);              // row full: run writes nothing
        send(8'h00, 1'b0);
        send(8'h00, 1'b0);             // absolute run clamping to zero, no bytes taken
        send(8'd5, 1'b0);
        send(8'h00, 1'b0);             // delta saturating at the image edge
        send(ESC_DELTA, 1'b0);
        send(8'hff, 1'b0);
        send(8'hff, 1'b0);
        drain();

        // Oversized width acts as the maximum; unknown index must change nothing.
        write_reg(CFG_UNUSED_INDEX, 15'h7fff);
        write_reg(CFG_IMAGE_WIDTH, 15'h7fff);
        write_reg(CFG_IMAGE_HEIGHT, 15'(MAX_DIMENSION_DEFAULT));
        write_reg(CFG_NIBBLE_MODE, 15'd1);
        send(8'h00, 1'b0);             // five nibbles: three bytes and a pad
        send(8'd5, 1'b0);
        send(8'h12, 1'b0);
        send(8'h34, 1'b0);
        send(8'h56, 1'b0);
        send(8'h00, 1'b0);
        send(8'd3, 1'b0);              // nibble run alternating a and 5
        send(8'ha5, 1'b0);
        send(8'h00, 1'b0);             // end of line
        send(ESC_END_LINE, 1'b0);
        send(8'h00, 1'b0);             // three nibbles: two bytes, no pad
        send(8'd3, 1'b0);
        send(8'hf0, 1'b0);
        send(8'h0f, 1'b0);

        // Random part; each phase boundary may fall mid-run, so mode switches
        // land inside absolute runs too.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            send_idle_pct = (p / 2 == 0) ? 9 : (p / 2 == 1) ? 77 : 0;
            recv_idle_pct = (p / 2 == 0) ? 77 : (p / 2 == 1) ? 9 : 0;
            write_reg(CFG_NIBBLE_MODE, DIM_CFG_W'(p[0]));
            case (p)
                0: write_reg(CFG_IMAGE_WIDTH, 15'($urandom_range(2, 24)));
                1: write_reg(CFG_IMAGE_WIDTH, 15'(MAX_DIMENSION_DEFAULT));
                2: write_reg(CFG_IMAGE_WIDTH, 15'($urandom_range(100, 400)));
                3: write_reg(CFG_IMAGE_WIDTH, 15'($urandom_range(1, 8)));
                4: write_reg(CFG_IMAGE_WIDTH, 15'(MAX_DIMENSION_DEFAULT - 1));
                default: write_reg(CFG_IMAGE_WIDTH, 15'($urandom_range(8, 64)));
            endcase
            write_reg(CFG_IMAGE_HEIGHT, p[0] ? 15'h7fff : 15'(MAX_DIMENSION_DEFAULT));
            repeat (PHASE_BYTES)
                send(pick_byte(plan_state), 1'b0);
        end

        // One way of finishing per run, picked by the seed.
        ending = $urandom_range(0, 3);
        case (ending)
            0: send(BYTE_W'($urandom), 1'b1);          // stream end in whatever phase
            1: begin                                   // end-of-bitmap marker
                settle();
                send(8'h00, 1'b0);
                send(ESC_END_BITMAP, 1'b0);
            end
            2: begin                                   // end of line on the last line
                settle();
                drain();
                write_reg(CFG_IMAGE_HEIGHT, plan_state.line + 1'b1);
                send(8'h00, 1'b0);
                send(ESC_END_LINE, 1'b0);
            end
            default: begin                             // height set to the current line index
                drain();
                write_reg(CFG_IMAGE_HEIGHT, plan_state.line);
                send(BYTE_W'($urandom), 1'b0);
            end
        endcase
        // after finishing everything is swallowed without a descriptor
        repeat (5)
            send(BYTE_W'($urandom), 1'($urandom));
        send(BYTE_W'($urandom), 1'b1);
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
